/* rtl/ntc_pkg.sv */
// Package with the constants, types and the helper function of the NTC temperature converter.
`timescale 1ns / 1ps
`default_nettype none
package ntc_pkg;

   // Converter resolution and full-scale code.
   localparam int AdcBits   = 12;
   localparam int FullScale = (1 << AdcBits) - 1;

   // Field and register widths.
   localparam int SampleW = 12;
   localparam int TempW   = 18;
   localparam int ResW    = 20;
   localparam int BetaW   = 14;
   localparam int NomW    = 15;
   localparam int CsrIdxW = 8;

   // Datapath widths.
   localparam int MulW  = 33;
   localparam int ProdW = 2 * MulW;
   localparam int NumW  = 54;
   localparam int DenW  = 42;

   // Register indexes of the configuration port.
   localparam logic [CsrIdxW-1:0] CsrSeries  = 8'd0;
   localparam logic [CsrIdxW-1:0] CsrNominal = 8'd1;
   localparam logic [CsrIdxW-1:0] CsrBeta    = 8'd2;
   localparam logic [CsrIdxW-1:0] CsrNomTemp = 8'd3;

   // Arithmetic constants.
   localparam logic [15:0] Ln2Q16      = 16'd45426;
   localparam logic [22:0] ScaleB      = 23'd6553600;
   localparam int          KelvinCenti = 27315;
   localparam int          TempMax     = 100000;
   localparam int          TempMin     = -27315;
   localparam int          SatLimit    = TempMax + KelvinCenti;

   // Status returned by the divider.
   typedef struct packed {
      logic            done;
      logic [NumW-1:0] quot;
   } div_stat_type;

   // Index of the highest set bit of a resistance or sample value.
   function automatic logic [4:0] lead_one(input logic [ResW-1:0] x);
      logic [4:0] pos;
      pos = 5'd0;
      for (int i = 0; i < ResW; i++) begin
         if (x[i]) begin
            pos = 5'(i);
         end
      end
      return pos;
   endfunction

endpackage
`default_nettype wire

/* rtl/ntc_mul.sv */
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module ntc_mul
   import ntc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic signed [MulW-1:0]  mul_a,
   input  wire logic signed [MulW-1:0]  mul_b,
   output      logic signed [ProdW-1:0] mul_p_ff
);

   logic signed [ProdW-1:0] mul_p_in;

   // One product per cycle; it is visible in the following cycle.
   assign mul_p_in = ProdW'(mul_a) * ProdW'(mul_b);

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_p_in;
   end

endmodule
`default_nettype wire

/* rtl/ntc_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ntc_div
   import ntc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            div_start,
   input  wire logic [NumW-1:0] div_num,
   input  wire logic [DenW-1:0] div_den,
   output      div_stat_type    div_stat
);

   logic [NumW-1:0] num_ff, num_in;
   logic [NumW-1:0] quot_ff, quot_in;
   logic [DenW:0]   rem_ff, rem_in;
   logic [DenW-1:0] den_ff, den_in;
   logic [5:0]      count_ff, count_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DenW:0]   rem_shift;
   logic            fits;

   // Shift in the next numerator bit and try to subtract the divisor.
   assign rem_shift = {rem_ff[DenW-1:0], num_ff[NumW-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      num_in   = num_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (div_start) begin
         num_in   = div_num;
         den_in   = div_den;
         rem_in   = '0;
         quot_in  = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         num_in   = {num_ff[NumW-2:0], 1'b0};
         rem_in   = fits ? (rem_shift - {1'b0, den_ff}) : rem_shift;
         quot_in  = {quot_ff[NumW-2:0], fits};
         count_in = count_ff + 6'd1;
         if (count_ff == 6'(NumW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign div_stat.done = done_ff;
   assign div_stat.quot = quot_ff;

endmodule
`default_nettype wire

/* rtl/ntc_thermistor_to_celsius.sv */
// Top level: sequencer that converts an NTC divider sample to hundredths of a degree Celsius.
// Steps from request to result: four base-2 logs on the shared multiplier, each made of squaring
// rounds (a multiply state and an accumulate state), five multiplies (a multiply state and a state
// that takes the product), a check state, the divider and a finish state that loads the result.
// A held sample or a zero resistance goes straight to the finish state. The next request is taken
// once the result is in the output register. Reset restores the register defaults and 25.00 C.
`timescale 1ns / 1ps
`default_nettype none
module ntc_thermistor_to_celsius
   import ntc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic [SampleW-1:0]  req_adc_sample,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic signed [TempW-1:0] rsp_temp_centi,
   output      logic                rsp_held,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [ResW-1:0]     csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOG_INIT, ST_LOG_MUL, ST_LOG_ACC, ST_LN_MUL, ST_LN_RND,
      ST_BT_MUL, ST_BT_SAVE, ST_N_MUL, ST_N_SAVE, ST_BS_MUL, ST_BS_SAVE,
      ST_TL_MUL, ST_TL_ADD, ST_CHECK, ST_DIV, ST_FINISH
   } state_type;

   state_type                state_ff;
   logic [ResW-1:0]          series_ff, nominal_ff;
   logic [BetaW-1:0]         beta_ff;
   logic signed [NomW-1:0]   nom_temp_ff;
   logic signed [TempW-1:0]  last_temp_ff;
   logic [AdcBits-1:0]       sample_ff;
   logic [1:0]               log_idx_ff;
   logic [3:0]               round_ff;
   logic [4:0]               exp_ff;
   logic [30:0]              mant_ff;
   logic [15:0]              frac_ff;
   logic signed [22:0]       sum_ff;
   logic signed [23:0]       lq_ff;
   logic [29:0]              bt_ff;
   logic [NumW-1:0]          n_ff;
   logic signed [DenW:0]     d_ff;
   logic signed [TempW-1:0]  res_temp_ff;
   logic                     res_held_ff;
   logic                     rsp_valid_ff;
   logic signed [TempW-1:0]  rsp_temp_ff;
   logic                     rsp_held_ff;

   logic signed [MulW-1:0]   mul_a, mul_b;
   logic signed [ProdW-1:0]  mul_p;
   logic                     div_start;
   logic [NumW-1:0]          div_num;
   div_stat_type             div_stat;

   logic [AdcBits-1:0]       req_sample;
   logic [ResW-1:0]          log_x;
   logic [4:0]               log_e;
   logic [32:0]              sq_shift;
   logic [20:0]              log_term;
   logic [15:0]              t0;
   logic [39:0]              ln_mag;
   logic [23:0]              ln_r;
   logic signed [TempW-1:0]  div_temp;

   assign req_ready      = (state_ff == ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_temp_centi = rsp_temp_ff;
   assign rsp_held       = rsp_held_ff;
   assign req_sample     = req_adc_sample[AdcBits-1:0];

   // Operand of the current log: series, sample, complement, nominal.
   always_comb begin
      unique case (log_idx_ff)
         2'd0:    log_x = series_ff;
         2'd1:    log_x = ResW'(sample_ff);
         2'd2:    log_x = ResW'(AdcBits'(FullScale) - sample_ff);
         default: log_x = nominal_ff;
      endcase
   end
   assign log_e    = lead_one(log_x);
   assign sq_shift = mul_p[62:30];
   assign log_term = {exp_ff, frac_ff[14:0], sq_shift[31]};

   // Nominal temperature in centikelvin; always positive for a 15-bit register.
   assign t0 = 16'(17'($signed({nom_temp_ff[NomW-1], nom_temp_ff}) + 17'sd27315));

   // Round the scaled log half away from zero.
   assign ln_mag = mul_p[39] ? 40'(-mul_p[39:0]) : mul_p[39:0];
   assign ln_r   = 24'((ln_mag + 40'd32768) >> 16);

   // Divider result converted back to Celsius with saturation.
   assign div_temp = (div_stat.quot >= NumW'(SatLimit)) ? TempW'(TempMax)
                   : TempW'($signed({1'b0, div_stat.quot[16:0]}) - 18'sd27315);

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_LOG_MUL: begin
            mul_a = MulW'(mant_ff);
            mul_b = MulW'(mant_ff);
         end
         ST_LN_MUL: begin
            mul_a = MulW'(sum_ff);
            mul_b = MulW'(Ln2Q16);
         end
         ST_BT_MUL: begin
            mul_a = MulW'(beta_ff);
            mul_b = MulW'(t0);
         end
         ST_N_MUL: begin
            mul_a = MulW'(bt_ff);
            mul_b = MulW'(ScaleB);
         end
         ST_BS_MUL: begin
            mul_a = MulW'(beta_ff);
            mul_b = MulW'(ScaleB);
         end
         ST_TL_MUL: begin
            mul_a = MulW'(t0);
            mul_b = MulW'(lq_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign div_start = (state_ff == ST_CHECK) && (d_ff > 0);
   assign div_num   = n_ff + NumW'(d_ff[DenW:1]);

   ntc_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_p_ff (mul_p)
   );

   ntc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_num   (div_num),
      .div_den   (d_ff[DenW-1:0]),
      .div_stat  (div_stat)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff   <= 20'd10000;
         nominal_ff  <= 20'd10000;
         beta_ff     <= 14'd3950;
         nom_temp_ff <= 15'sd2500;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrSeries:  series_ff   <= csr_wdata;
            CsrNominal: nominal_ff  <= csr_wdata;
            CsrBeta:    beta_ff     <= csr_wdata[BetaW-1:0];
            CsrNomTemp: nom_temp_ff <= $signed(csr_wdata[NomW-1:0]);
            default: ;
         endcase
      end
   end

   // Sequencer, datapath registers and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_temp_ff <= 18'sd2500;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The finish state reloads the result register itself.
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  sample_ff   <= req_sample;
                  log_idx_ff  <= 2'd0;
                  sum_ff      <= '0;
                  res_held_ff <= 1'b0;
                  if (req_sample == '0 || req_sample >= AdcBits'(FullScale)) begin
                     res_temp_ff <= last_temp_ff;
                     res_held_ff <= 1'b1;
                     state_ff    <= ST_FINISH;
                  end else if (series_ff == '0 || nominal_ff == '0) begin
                     res_temp_ff <= TempW'(TempMin);
                     state_ff    <= ST_FINISH;
                  end else begin
                     state_ff <= ST_LOG_INIT;
                  end
               end
            end
            ST_LOG_INIT: begin
               exp_ff   <= log_e;
               mant_ff  <= 31'(31'(log_x) << (5'd30 - log_e));
               frac_ff  <= '0;
               round_ff <= '0;
               state_ff <= ST_LOG_MUL;
            end
            ST_LOG_MUL: begin
               state_ff <= ST_LOG_ACC;
            end
            ST_LOG_ACC: begin
               mant_ff  <= sq_shift[31] ? sq_shift[31:1] : sq_shift[30:0];
               frac_ff  <= {frac_ff[14:0], sq_shift[31]};
               round_ff <= round_ff + 4'd1;
               if (round_ff == 4'd15) begin
                  if (log_idx_ff[1]) begin
                     sum_ff <= sum_ff - $signed({2'b00, log_term});
                  end else begin
                     sum_ff <= sum_ff + $signed({2'b00, log_term});
                  end
                  log_idx_ff <= log_idx_ff + 2'd1;
                  state_ff   <= (log_idx_ff == 2'd3) ? ST_LN_MUL : ST_LOG_INIT;
               end else begin
                  state_ff <= ST_LOG_MUL;
               end
            end
            ST_LN_MUL: begin
               state_ff <= ST_LN_RND;
            end
            ST_LN_RND: begin
               lq_ff    <= mul_p[39] ? $signed(-ln_r) : $signed(ln_r);
               state_ff <= ST_BT_MUL;
            end
            ST_BT_MUL: begin
               state_ff <= ST_BT_SAVE;
            end
            ST_BT_SAVE: begin
               bt_ff    <= mul_p[29:0];
               state_ff <= ST_N_MUL;
            end
            ST_N_MUL: begin
               state_ff <= ST_N_SAVE;
            end
            ST_N_SAVE: begin
               n_ff     <= mul_p[NumW-1:0];
               state_ff <= ST_BS_MUL;
            end
            ST_BS_MUL: begin
               state_ff <= ST_BS_SAVE;
            end
            ST_BS_SAVE: begin
               d_ff     <= mul_p[DenW:0];
               state_ff <= ST_TL_MUL;
            end
            ST_TL_MUL: begin
               state_ff <= ST_TL_ADD;
            end
            ST_TL_ADD: begin
               d_ff     <= d_ff + mul_p[DenW:0];
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               // Zero denominator is infinite heat, a negative one is below absolute zero.
               if (d_ff == '0) begin
                  res_temp_ff <= TempW'(TempMax);
                  state_ff    <= ST_FINISH;
               end else if (d_ff < 0) begin
                  res_temp_ff <= TempW'(TempMin);
                  state_ff    <= ST_FINISH;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_stat.done) begin
                  res_temp_ff <= div_temp;
                  state_ff    <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_temp_ff  <= res_temp_ff;
                  rsp_held_ff  <= res_held_ff;
                  if (!res_held_ff) begin
                     last_temp_ff <= res_temp_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

/* rtl/ntc_checker.sv */
// Port-level checker for the NTC converter and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ntc_checker
   import ntc_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [TempW-1:0]    rsp_temp_centi,
   input wire logic                rsp_held
);

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temp_centi) && $stable(rsp_held))
      else $error("result changed while stalled");

   // The block is busy in the cycle after it takes a request.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // Every temperature stays inside the saturation range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_temp_centi) >= -18'sd27315)
                 && ($signed(rsp_temp_centi) <= 18'sd100000))
      else $error("temperature out of range");

endmodule

bind ntc_thermistor_to_celsius ntc_checker u_ntc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_temp_centi (rsp_temp_centi),
   .rsp_held       (rsp_held)
);
`default_nettype wire
